### sv/fh64_pkg.sv
// ============================================================================
// fh64_pkg: shared types and constants for the fasthash64 stream block
// Holds the hash constants, the queue item and status structs and the mix
// helper functions.
// ============================================================================
package fh64_pkg;

    localparam logic [63:0] FH_MUL     = 64'h8803_55f2_1e6d_1965;
    localparam logic [63:0] FH_MIX_MUL = 64'h2127_599b_f432_5c37;
    localparam int          SHIFT_A    = 23;
    localparam int          SHIFT_B    = 47;
    localparam int          WORD_BYTES = 8;
    localparam logic [16:0] COUNT_MAX  = 17'h1_FFFF;

    // configuration register indexes
    localparam logic [7:0]  REG_HASH_SEED      = 8'd0;
    localparam logic [7:0]  REG_MESSAGE_LENGTH = 8'd1;

    // one classified word, as queued between front and back
    typedef struct packed {
        logic [63:0] word;     // masked to the valid bytes
        logic [3:0]  nbytes;   // clamped to 0..8
        logic        last;
    } fh64_item_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic mul_start;
        logic mul_busy;
        logic mul_done;
        logic in_msg;
    } fh64_status_t;

    function automatic logic [63:0] mix_pre(input logic [63:0] x);
        return x ^ (x >> SHIFT_A);
    endfunction

    function automatic logic [63:0] mix_post(input logic [63:0] x);
        return x ^ (x >> SHIFT_B);
    endfunction

endpackage

### sv/fh64_front.sv
// ============================================================================
// fh64_front: input side
// Takes stream transfers, clamps the byte count and masks unused bytes.
// ============================================================================
module fh64_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [71:0]         s_tdata,
    input  logic                s_tlast,
    input  logic                q_ready,
    output logic                q_push,
    output fh64_pkg::fh64_item_t q_item
);
    import fh64_pkg::*;

    logic [3:0]  nb;
    logic [63:0] masked;

    always_comb
    begin
        nb = (s_tdata[67:64] > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : s_tdata[67:64];
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            masked[i*8 +: 8] = (4'(i) < nb) ? s_tdata[i*8 +: 8] : 8'h00;
        end
    end

    assign s_tready      = q_ready;
    assign q_push        = s_tvalid && q_ready;
    assign q_item.word   = masked;
    assign q_item.nbytes = nb;
    assign q_item.last   = s_tlast;

endmodule

### sv/fh64_queue.sv
// ============================================================================
// fh64_queue: two-entry item queue
// Decouples the input side from the hash engine.
// ============================================================================
module fh64_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fh64_pkg::fh64_item_t push_item,
    output logic                 in_ready,
    input  logic                 pop,
    output logic                 out_valid,
    output fh64_pkg::fh64_item_t out_item
);
    import fh64_pkg::*;

    fh64_item_t  buf_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = buf_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/fh64_mul.sv
// ============================================================================
// fh64_mul: iterative 64x64 multiplier, low 64 bits of the product
// One 32x32 multiplier, three partial products, registered between steps.
// ============================================================================
module fh64_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        busy,
    output logic        done,
    output logic [63:0] result
);
    logic [63:0] a_reg, b_reg;
    logic [63:0] pr_reg, pr_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  phase_reg, phase_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] op_a, op_b;

    // phase 0: lo*lo, phase 1: hi*lo, phase 2: lo*hi, phase 3: last add
    always_comb
    begin
        op_a       = (phase_reg == 2'd1) ? a_reg[63:32] : a_reg[31:0];
        op_b       = (phase_reg == 2'd2) ? b_reg[63:32] : b_reg[31:0];
        pr_next    = 64'(op_a) * 64'(op_b);
        acc_next   = acc_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            phase_next = 2'd0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            phase_next = phase_reg + 2'd1;
            if (phase_reg == 2'd1)
            begin
                acc_next = pr_reg;
            end
            else if (phase_reg != 2'd0)
            begin
                acc_next = acc_reg + {pr_reg[31:0], 32'h0};
            end
            if (phase_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        pr_reg  <= pr_next;
        acc_reg <= acc_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

endmodule

### sv/fh64_back.sv
// ============================================================================
// fh64_back: hash engine
// Sequences init, mix, fold and finalize over the shared multiplier and
// holds the result in an output register.
// ============================================================================
module fh64_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  fh64_pkg::fh64_item_t   q_item,
    output logic                   q_pop,
    input  logic [63:0]            hash_seed,
    input  logic [15:0]            message_length,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,
    output logic                   m_tuser,
    output fh64_pkg::fh64_status_t status
);
    import fh64_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INIT = 6'b000010,
        S_MIX  = 6'b000100,
        S_FOLD = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    fh64_item_t  item_reg, item_next;
    logic [63:0] acc_reg, acc_next;
    logic [16:0] bytes_reg, bytes_next;
    logic        in_msg_reg, in_msg_next;
    logic [63:0] hash_reg, hash_next;
    logic        err_reg, err_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_hash_reg, out_hash_next;
    logic        out_err_reg, out_err_next;
    logic [17:0] bytes_sum;

    logic        mul_start, mul_busy, mul_done;
    logic [63:0] mul_a, mul_b, mul_result;

    // where a word goes once the accumulator is set up
    function automatic state_t route(input fh64_item_t it);
        if (it.nbytes != 4'd0)
        begin
            return S_MIX;
        end
        else if (it.last)
        begin
            return S_FIN;
        end
        return S_IDLE;
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        acc_next       = acc_reg;
        bytes_next     = bytes_reg;
        in_msg_next    = in_msg_reg;
        hash_next      = hash_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        out_err_next   = out_err_reg;
        q_pop          = 1'b0;
        bytes_sum      = {1'b0, bytes_reg} + 18'(item_reg.nbytes);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (!in_msg_reg)
                    begin
                        state_next = S_INIT;
                        bytes_next = '0;
                    end
                    else
                    begin
                        state_next = route(q_item);
                    end
                end
            end
            S_INIT:
            begin
                if (mul_done)
                begin
                    acc_next    = hash_seed ^ mul_result;
                    in_msg_next = 1'b1;
                    state_next  = route(item_reg);
                end
            end
            S_MIX:
            begin
                if (mul_done)
                begin
                    acc_next   = acc_reg ^ mix_post(mul_result);
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_result;
                    bytes_next = bytes_sum[17] ? COUNT_MAX : bytes_sum[16:0];
                    state_next = item_reg.last ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if (mul_done)
                begin
                    hash_next   = mix_post(mul_result);
                    err_next    = ({1'b0, message_length} != bytes_reg);
                    in_msg_next = 1'b0;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = hash_reg;
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // launch a multiply on entry to each arithmetic state
        mul_start = (state_next != state_reg) &&
                    (state_next == S_INIT || state_next == S_MIX ||
                     state_next == S_FOLD || state_next == S_FIN);
        unique case (state_next)
            S_INIT:
            begin
                mul_a = {48'h0, message_length};
                mul_b = FH_MUL;
            end
            S_MIX:
            begin
                mul_a = mix_pre(item_next.word);
                mul_b = FH_MIX_MUL;
            end
            S_FIN:
            begin
                mul_a = mix_pre(acc_next);
                mul_b = FH_MIX_MUL;
            end
            default:
            begin
                mul_a = acc_next;
                mul_b = FH_MUL;
            end
        endcase
    end

    fh64_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            bytes_reg     <= '0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            bytes_reg     <= bytes_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        hash_reg     <= hash_next;
        err_reg      <= err_next;
        out_hash_reg <= out_hash_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_hash_reg;
    assign m_tuser          = out_err_reg;
    assign status.mul_start = mul_start;
    assign status.mul_busy  = mul_busy;
    assign status.mul_done  = mul_done;
    assign status.in_msg    = in_msg_reg;

endmodule

### sv/fasthash64_stream_top.sv
// ============================================================================
// fasthash64_stream_top: streaming fasthash64 of a byte message
// Top level with the configuration registers, input side, queue and engine.
// ============================================================================
// Hashes a message delivered as 64-bit words of up to eight little-endian
// bytes and returns one 64-bit fasthash64 result per message, on the word
// marked with tlast, together with a flag that is set when the bytes delivered
// differ from message_length. All 64x64 products go through one shared 32x32
// multiplier in three partial-product steps, and that unit sets the rate: a
// word with data is pulled from the queue, then takes a mix multiply and a
// fold multiply; the first word of a message adds the seed/length setup
// multiply, and the last word adds the final mix multiply and the hand-off to
// the output register. An empty word needs no mix or fold multiply. The
// engine takes one word at a time. A two-entry queue sits between
// the input side and the engine, and the output register lets the engine move
// on while a result waits to be taken. hash_seed and message_length are taken
// on the first word; message_length is compared again at the last word.
// Write configuration only while no message work is outstanding.
// ============================================================================
module fasthash64_stream_top (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // [63:0] data_word, [67:64] word_bytes, [71:68] zero
    input  logic        s_tlast,    // last_word
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] hash_value
    output logic        m_tuser,    // [0] length_error
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import fh64_pkg::*;

    logic [63:0]  hash_seed_reg, hash_seed_next;
    logic [15:0]  msg_len_reg, msg_len_next;

    logic         q_push, q_in_ready, q_pop, q_out_valid;
    fh64_item_t   push_item, head_item;
    fh64_status_t status;

    // configuration is always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        hash_seed_next = hash_seed_reg;
        msg_len_next   = msg_len_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HASH_SEED:
                begin
                    hash_seed_next = cfg_data;
                end
                REG_MESSAGE_LENGTH:
                begin
                    msg_len_next = cfg_data[15:0];
                end
                default:
                begin
                    hash_seed_next = hash_seed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg <= '0;
            msg_len_reg   <= '0;
        end
        else
        begin
            hash_seed_reg <= hash_seed_next;
            msg_len_reg   <= msg_len_next;
        end
    end

    // input side: clamp byte count, mask unused bytes
    fh64_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_ready  (q_in_ready),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // short queue so input and engine stall independently
    fh64_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .in_ready  (q_in_ready),
        .pop       (q_pop),
        .out_valid (q_out_valid),
        .out_item  (head_item)
    );

    // hash engine with shared multiplier and output register
    fh64_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_out_valid),
        .q_item         (head_item),
        .q_pop          (q_pop),
        .hash_seed      (hash_seed_reg),
        .message_length (msg_len_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .status         (status)
    );

    // the multiplier is never restarted while a product is in flight
    a_mul_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_start |-> !status.mul_busy)
        else $error("multiply started while busy");

    // a running multiply ends only through its done pulse
    a_mul_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_busy |=> (status.mul_busy || status.mul_done))
        else $error("multiply dropped without done");

    // a result appears only once its message is closed
    a_result_closes_msg: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !status.in_msg)
        else $error("result shown while message still open");

endmodule

### sim/tb_fasthash64_stream_top.sv
// ============================================================================
// tb_fasthash64_stream_top: self-checking bench for the fasthash64 stream
// Drives messages word by word through the input stream, predicts each
// message hash and length flag in the bench, and checks every result
// transfer in order, under random stalls on both sides and several
// seed and length settings.
// ============================================================================
module tb_fasthash64_stream_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fh64_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYCLES = 8;
    localparam int TAIL_CYCLES = 40;        // well beyond the last-word latency
    localparam int CYCLE_LIMIT = 250_000;   // watchdog limit, well above a full run
    localparam int PHASE_ITEMS = 210;

    // indexes past the register list, writes to them must be dropped
    localparam logic [7:0] REG_PAST_END = 8'd2;
    localparam logic [7:0] REG_TOP      = 8'hFF;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } msg_word_t;

    typedef struct packed {
        logic [63:0] hash;
        logic        len_err;
    } hash_result_t;

    // dut ports
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // [63:0] data_word, [67:64] word_bytes, [71:68] zero
    logic        s_tlast;   // last_word
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] hash_value
    logic        m_tuser;   // [0] length_error
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [63:0] cfg_data;

    // stimulus and expected results
    msg_word_t    pending_words[$];
    hash_result_t expected_hashes[$];
    msg_word_t    shown_word;      // word currently on the input bus
    hash_result_t oldest_hash;

    // bench copy of the block state and registers
    logic [63:0] seed_setting;
    logic [15:0] length_setting;
    logic [63:0] hash_acc;
    logic        msg_open;
    logic [16:0] byte_count;

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int cycle_count;

    fasthash64_stream_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // hash arithmetic, all products modulo 2^64
    // ------------------------------------------------------------------------

    // xorshift, multiply, xorshift
    function automatic logic [63:0] scramble64(input logic [63:0] x);
        logic [63:0] t;
        t = x ^ (x >> SHIFT_A);
        t = t * FH_MIX_MUL;
        return t ^ (t >> SHIFT_B);
    endfunction

    // fold one accepted input word into the running hash, queue the result
    // when the word closes the message
    task automatic absorb_word(input logic [63:0] word, input logic [3:0] nbytes,
                               input logic last);
        logic [3:0]  n;
        logic [63:0] w;
        logic [63:0] len64;
        logic [17:0] sum;
        n = (nbytes > 4'd8) ? 4'd8 : nbytes;   // oversized counts act as full words
        w = word;
        if (!msg_open)
        begin
            // registers are sampled on the first word of a message
            len64     = {48'd0, length_setting};
            hash_acc  = seed_setting ^ (len64 * FH_MUL);
            byte_count = '0;
            msg_open  = 1'b1;
        end
        if (n != 4'd0)
        begin
            // bytes past the valid count are zero for the hash
            if (n < 4'd8)
                w = word & ((64'd1 << (n * 8)) - 64'd1);
            hash_acc = (hash_acc ^ scramble64(w)) * FH_MUL;
            sum = {1'b0, byte_count} + {14'd0, n};
            byte_count = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[16:0];
        end
        if (last)
        begin
            expected_hashes.push_back('{scramble64(hash_acc),
                                        byte_count != {1'b0, length_setting}});
            msg_open = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    task automatic push_word(input logic [63:0] word, input logic [3:0] nbytes,
                             input logic last);
        pending_words.push_back('{word, nbytes, last});
    endtask

    // well-formed message: full words, then the remainder on the last word
    task automatic queue_message(input int total, output int words);
        int rem;
        if (total == 0)
        begin
            push_word({$urandom(), $urandom()}, 4'd0, 1'b1);
            words = 1;
        end
        else
        begin
            words = (total + 7) / 8;
            rem   = total - (words - 1) * 8;
            for (int i = 0; i < words - 1; i++)
                push_word({$urandom(), $urandom()}, 4'd8, 1'b0);
            push_word({$urandom(), $urandom()}, rem[3:0], 1'b1);
        end
    endtask

    // mostly well-formed messages, some with random counts and short words;
    // every message still ends on a last word so the block goes idle
    task automatic queue_random_items(input int quota);
        int added;
        int total;
        int words;
        added = 0;
        while (added < quota)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                if (length_setting <= 16'd64 && $urandom_range(0, 1) == 1)
                    total = int'(length_setting);
                else
                    total = $urandom_range(0, 64);
                queue_message(total, words);
            end
            else
            begin
                words = $urandom_range(1, 6);
                for (int i = 0; i < words; i++)
                    push_word({$urandom(), $urandom()}, 4'($urandom_range(0, 15)),
                              i == words - 1);
            end
            added += words;
        end
    endtask

    // wait until every word is taken and every result has come back;
    // sampled mid-cycle so driver and monitor updates have settled
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || s_tvalid || expected_hashes.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // one register write transfer, bench copy updated once it is taken
    task automatic write_reg(input logic [7:0] index, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_HASH_SEED)
            seed_setting = value;
        else if (index == REG_MESSAGE_LENGTH)
            length_setting = value[15:0];
    endtask

    // ------------------------------------------------------------------------
    // input driver: presents queued words, predicts on each accepted transfer
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                absorb_word(shown_word.word, shown_word.nbytes, shown_word.last);
            // bus is free after this edge: show the next word or idle
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    shown_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'd0, shown_word.nbytes, shown_word.word};
                    s_tlast  <= shown_word.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: random backpressure, in-order compare
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    report_mismatch("result with nothing expected", m_tdata, 64'd0);
                end
                else
                begin
                    oldest_hash = expected_hashes.pop_front();
                    if (m_tdata !== oldest_hash.hash)
                        report_mismatch("hash_value", m_tdata, oldest_hash.hash);
                    if (m_tuser !== oldest_hash.len_err)
                        report_mismatch("length_error", {63'd0, m_tuser},
                                        {63'd0, oldest_hash.len_err});
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int words;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        seed_setting   = '0;
        length_setting = '0;
        hash_acc       = '0;
        msg_open       = 1'b0;
        byte_count     = '0;
        send_idle_pct  = 24;
        recv_idle_pct  = 71;
        error_count    = 0;
        cycle_count    = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed words under reset registers (seed 0, length 0)
        push_word({$urandom(), $urandom()}, 4'd0, 1'b1);     // empty message, length matches
        push_word('1, 4'd8, 1'b1);                            // all-ones full word
        push_word('0, 4'd8, 1'b1);                            // all-zero full word
        for (int n = 1; n < 8; n++)
            push_word('1, n[3:0], 1'b1);                      // masking of each short count
        push_word('1, 4'd9, 1'b1);                            // oversized counts act as 8
        push_word({$urandom(), $urandom()}, 4'd15, 1'b1);
        // empty word opens the message, short word mid-message, empty word closes it
        push_word({$urandom(), $urandom()}, 4'd0, 1'b0);
        push_word({$urandom(), $urandom()}, 4'd8, 1'b0);
        push_word({$urandom(), $urandom()}, 4'd3, 1'b0);
        push_word({$urandom(), $urandom()}, 4'd8, 1'b0);
        push_word({$urandom(), $urandom()}, 4'd0, 1'b1);
        push_word({$urandom(), $urandom()}, 4'd12, 1'b0);
        push_word({$urandom(), $urandom()}, 4'd5, 1'b1);
        wait_quiet();

        // phase one: slow receiver
        write_reg(REG_HASH_SEED, {$urandom(), $urandom()});
        write_reg(REG_MESSAGE_LENGTH, 64'($urandom_range(0, 48)));
        write_reg(REG_PAST_END, {$urandom(), $urandom()});
        queue_random_items(PHASE_ITEMS);
        wait_quiet();

        // phase two: slow sender, register extremes first
        send_idle_pct = 71;
        recv_idle_pct = 24;
        write_reg(REG_HASH_SEED, '1);
        write_reg(REG_MESSAGE_LENGTH, 64'hFFFF);
        write_reg(REG_TOP, '0);
        queue_random_items(PHASE_ITEMS / 2);
        // hold the sender until every result is back, then retune
        wait_quiet();
        write_reg(REG_HASH_SEED, {$urandom(), $urandom()});
        write_reg(REG_MESSAGE_LENGTH, 64'd8);
        queue_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
        wait_quiet();

        // phase three: no idling; a long message against the largest length
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_HASH_SEED, {$urandom(), $urandom()});
        write_reg(REG_MESSAGE_LENGTH, 64'hFFFF);
        queue_message(256, words);
        wait_quiet();
        write_reg(REG_HASH_SEED, '0);
        write_reg(REG_MESSAGE_LENGTH, 64'd1);
        queue_random_items(PHASE_ITEMS);
        wait_quiet();

        if (expected_hashes.size() != 0)
            report_mismatch("results never delivered", 64'(expected_hashes.size()),
                            64'd0);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
sv/fh64_pkg.sv
sv/fh64_front.sv
sv/fh64_queue.sv
sv/fh64_mul.sv
sv/fh64_back.sv
sv/fasthash64_stream_top.sv
sim/tb_fasthash64_stream_top.sv
